// ===== rtl/core/limo3_pkg.sv =====
// ----------------------------------------------------------------------------
// LimO3 limiter package
// Widths, register indexes and the shared cell payload type.
// ----------------------------------------------------------------------------
package limo3_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int W_SAMPLE = 32;
    localparam int W_D      = 33;
    localparam int W_THR    = 48;
    localparam int W_BAND   = 17;
    localparam int W_CFG    = 48;
    localparam int W_IDX    = 2;
    localparam int W_ETA    = 41;   // eta capped at 2^40

    localparam logic [W_IDX-1:0] REG_INV_THRESHOLD_SQ = 2'd0;
    localparam logic [W_IDX-1:0] REG_ETA_BAND         = 2'd1;
    localparam logic [W_IDX-1:0] REG_INV_ETA_BAND     = 2'd2;

    // Remainder/quotient state of the ratio divider (64-bit quotient, 33-bit remainder)
    typedef struct packed {
        logic        vld;
        logic        neg;
        logic [63:0] num;     // shifting dividend / quotient
        logic [32:0] rem;
        logic [31:0] den;
        logic [65:0] sum;     // d1^2 + d2^2
    } t_div;

endpackage

// ===== rtl/core/limo3_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake carrying one payload word.
// ----------------------------------------------------------------------------
interface limo3_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/limo3_slope_limiter.sv =====
// ----------------------------------------------------------------------------
// LimO3 slope limiter
// Third order limiter factor with smoothness blending, Q(32-F).F.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries {value_n1, value_n2, value_q1, value_q2} (n1 in the top
//   word). o_out carries {limiter_value, ratio_saturated}. i_cfg writes a
//   register by index (0 inv_threshold_sq, 1 eta_band, 2 inv_eta_band);
//   out-of-range indexes are ignored. Write only while idle.
//   Throughput: one word per cycle unless the receiver stalls. Pipeline: two
//   front stages, the chain of 64 divider cells (one quotient bit each)
//   and six back-end stages ending in the output register. The whole pipe
//   advances as one; when the receiver stalls, the pipe holds and
//   i_in.ready drops only while the output register is full and not taken.
//   Reset (synchronous, active low) empties the pipe and loads register
//   defaults.
// ----------------------------------------------------------------------------
module limo3_slope_limiter
    import limo3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    limo3_if.sink   i_in,
    limo3_if.source o_out,
    limo3_if.sink   i_cfg
);
    localparam int NCELL = 64;
    localparam logic signed [W_ETA+2:0] ONE = (W_ETA+3)'(1) <<< FRAC_BITS;
    localparam longint C16 = ((64'sd8 <<< FRAC_BITS) + 2) / 5;

    logic [W_THR-1:0]  r_thr;
    logic [W_BAND-1:0] r_band;
    logic [W_CFG-1:0]  r_ieb;
    logic              en;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= W_THR'(48'd6553600);
            r_band <= W_BAND'(1);
            r_ieb  <= W_CFG'(48'd4294967296);
        end else if (i_cfg.valid) begin
            case (i_cfg.data[W_CFG +: W_IDX])
                REG_INV_THRESHOLD_SQ: r_thr  <= i_cfg.data[W_CFG-1:0];
                REG_ETA_BAND:         r_band <= i_cfg.data[W_BAND-1:0];
                REG_INV_ETA_BAND:     r_ieb  <= i_cfg.data[W_CFG-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: differences
    logic signed [W_D-1:0] d1, d2;
    logic r_v0, r_neg0;
    logic [31:0] r_m1, r_m2;
    assign d1 = W_D'($signed(i_in.data[127:96])) - W_D'($signed(i_in.data[95:64]));
    assign d2 = W_D'($signed(i_in.data[63:32])) - W_D'($signed(i_in.data[31:0]));
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en) r_v0 <= i_in.valid;
        if (en) begin
            r_m1   <= d1[W_D-1] ? 32'(-d1) : 32'(d1);
            r_m2   <= d2[W_D-1] ? 32'(-d2) : 32'(d2);
            r_neg0 <= d1[W_D-1] ^ d2[W_D-1];
        end
    end

    // stage 1: squares
    logic [63:0] r_sq1, r_sq2;
    logic [31:0] r_m1b, r_m2b;
    logic r_v1, r_neg1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= r_v0;
        if (en) begin
            r_sq1 <= 64'(r_m1) * 64'(r_m1);
            r_sq2 <= 64'(r_m2) * 64'(r_m2);
            r_m1b <= r_m1; r_m2b <= r_m2; r_neg1 <= r_neg0;
        end
    end

    // divider chain: quotient = (m1 << F) / m2
    t_div chain [NCELL+1];
    always_comb begin
        chain[0].vld = r_v1;
        chain[0].neg = r_neg1;
        chain[0].num = 64'(r_m1b) << FRAC_BITS;
        chain[0].rem = '0;
        chain[0].den = r_m2b;
        chain[0].sum = 66'(r_sq1) + 66'(r_sq2);
    end
    // |d2| < 2^32, so the divisor always fits 32 bits
    logic [NCELL:0] zf;
    assign zf[0] = (r_m2b == '0);
    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            logic r_z;
            limo3_div_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                .i_d(chain[g]), .o_d(chain[g+1])
            );
            always_ff @(posedge i_clk) if (en) r_z <= zf[g];
            assign zf[g+1] = r_z;
        end
    endgenerate

    logic [63:0] q;
    assign q = chain[NCELL].num;

    // back stage A: ratio, eta partial products
    logic signed [31:0] r_r;
    logic r_sat, r_va;
    logic [56:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [33:0] rv;
    logic sat_n;
    always_comb begin
        sat_n = 1'b0;
        rv = '0;
        if (!zf[NCELL]) begin
            if (chain[NCELL].neg) begin
                if (q > 64'h8000_0000) begin sat_n = 1'b1; rv = -34'sh8000_0000; end
                else rv = -$signed({1'b0, q[32:0]});
            end else begin
                if (q > 64'h7FFF_FFFF) begin sat_n = 1'b1; rv = 34'sh7FFF_FFFF; end
                else rv = $signed({1'b0, q[32:0]});
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (en) r_va <= chain[NCELL].vld;
        if (en) begin
            r_r <= rv[31:0]; r_sat <= sat_n;
            r_p0 <= 57'(chain[NCELL].sum[32:0])  * 57'(r_thr[23:0]);
            r_p1 <= 57'(chain[NCELL].sum[32:0])  * 57'(r_thr[47:24]);
            r_p2 <= 57'(chain[NCELL].sum[65:33]) * 57'(r_thr[23:0]);
            r_p3 <= 57'(chain[NCELL].sum[65:33]) * 57'(r_thr[47:24]);
        end
    end

    // stage B: s = (2 + r)/3 by reciprocal multiply, eta partial sums
    logic signed [33:0] sx, s_n;
    logic [31:0] sxm;
    logic [63:0] s3;
    logic signed [31:0] r_rb;
    logic signed [33:0] r_s;
    logic [81:0] r_ea, r_eb;
    logic r_vb, r_satb;
    always_comb begin
        sx  = (34'sd2 <<< FRAC_BITS) + 34'(r_r);
        sxm = sx[33] ? 32'(-sx) : 32'(sx);
        s3  = 64'(sxm) * 64'(32'hAAAA_AAAB);
        s_n = sx[33] ? -$signed({3'b0, s3[63:33]}) : $signed({3'b0, s3[63:33]});
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (en) r_vb <= r_va;
        if (en) begin
            r_s <= s_n; r_rb <= r_r; r_satb <= r_sat;
            r_ea <= 82'(r_p0) + (82'(r_p1) << 24);
            r_eb <= 82'(r_p2) + (82'(r_p3) << 24);
        end
    end

    // stage C: h, eta
    logic signed [33:0] h_n, half, a2r, m;
    logic [113:0] prod, esh;
    logic [W_ETA-1:0] eta_n;
    logic [W_ETA-1:0] r_eta;
    logic signed [33:0] r_sc, r_hc;
    logic r_vc, r_satc;
    function automatic logic signed [33:0] mn0(logic signed [33:0] a, logic signed [33:0] b);
        logic signed [33:0] t;
        t = (a < b) ? a : b;
        return (t < 0) ? 34'sd0 : t;
    endfunction
    function automatic logic signed [33:0] mx0(logic signed [33:0] a, logic signed [33:0] b);
        logic signed [33:0] t;
        t = (a > b) ? a : b;
        return (t < 0) ? 34'sd0 : t;
    endfunction
    always_comb begin
        half = (r_rb[31] ? 34'(-34'(r_rb)) : 34'(r_rb)) >>> 1;
        if (r_rb > 0) half = -half;
        a2r  = 34'(r_rb) <<< 1;
        m    = mn0(mn0(a2r, r_s), 34'(C16));
        m    = mx0(half, m);
        h_n  = mn0(r_s, m);
    end
    assign prod  = 114'(r_ea) + (114'(r_eb) << 33);
    assign esh   = prod >> (2*FRAC_BITS);
    assign eta_n = (esh > (114'(1) << 40)) ? W_ETA'(1) << 40 : esh[W_ETA-1:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (en) r_vc <= r_vb;
        if (en) begin
            r_eta <= eta_n; r_sc <= r_s; r_hc <= h_n; r_satc <= r_satb;
        end
    end

    // stage D: band compare, blend weight partial products
    // t only matters inside the band, where |eta - 1| < eta_band < 2^17
    logic signed [W_ETA+2:0] ediff;
    logic [W_BAND-1:0] emag;
    logic r_vd, r_satd, r_selh, r_sels, r_tneg;
    logic [40:0] r_tl, r_th;
    logic signed [33:0] r_sd, r_hd;
    assign ediff = $signed({3'b0, r_eta}) - ONE;
    assign emag  = ediff[W_ETA+2] ? W_BAND'(-ediff) : W_BAND'(ediff);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (en) r_vd <= r_vc;
        if (en) begin
            r_selh <= $signed({3'b0, r_eta}) >= ONE + $signed({27'd0, r_band});
            r_sels <= $signed({3'b0, r_eta}) <= ONE - $signed({27'd0, r_band});
            r_tl   <= 41'(emag) * 41'(r_ieb[23:0]);
            r_th   <= 41'(emag) * 41'(r_ieb[47:24]);
            r_tneg <= ediff[W_ETA+2];
            r_sd <= r_sc; r_hd <= r_hc; r_satd <= r_satc;
        end
    end

    // stage E: blend weight
    logic [64:0] tfull, tp;
    logic signed [W_ETA+2:0] t_n, r_t;
    logic signed [33:0] r_se, r_he;
    logic r_ve, r_sate, r_selhe, r_selse;
    assign tfull = 65'(r_tl) + (65'(r_th) << 24);
    assign tp    = tfull >> FRAC_BITS;
    always_comb begin
        t_n = (tp > 65'(ONE)) ? ONE : $signed((W_ETA+3)'(tp));
        if (r_tneg) t_n = -t_n;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ve <= 1'b0;
        else if (en) r_ve <= r_vd;
        if (en) begin
            r_t <= t_n; r_se <= r_sd; r_he <= r_hd; r_sate <= r_satd;
            r_selhe <= r_selh; r_selse <= r_sels;
        end
    end

    // stage F: blend and output register
    logic signed [31:0] phi_n;
    logic signed [95:0] mix;
    logic signed [95:0] fl;
    always_comb begin
        mix = 96'(ONE - r_t) * 96'(r_se) + 96'(ONE + r_t) * 96'(r_he);
        fl  = mix >>> (FRAC_BITS + 1);
        if (r_selhe)      fl = 96'(r_he);
        else if (r_selse) fl = 96'(r_se);
        if (fl > 96'sh7FFF_FFFF) phi_n = 32'sh7FFF_FFFF;
        else if (fl < -96'sh8000_0000) phi_n = -32'sh8000_0000;
        else phi_n = fl[31:0];
    end

    logic r_ov;
    logic [32:0] r_od;
    assign en = !r_ov || o_out.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r_ve;
        if (en) r_od <= {phi_n, r_sate};
    end
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_od)) else $error("output dropped");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> i_in.ready) else $error("stall while empty");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && zf[NCELL] |-> !sat_n) else $error("sat on zero divisor");
endmodule

// ===== rtl/core/limo3_div_cell.sv =====
// ----------------------------------------------------------------------------
// Ratio divider cell
// One restoring division step per cell; cells form a chain.
// ----------------------------------------------------------------------------
module limo3_div_cell
    import limo3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);
    t_div        n_d;
    t_div        r_d;
    logic [33:0] trial;
    logic [32:0] sh;

    always_comb begin
        n_d   = i_d;
        sh    = {i_d.rem[31:0], i_d.num[63]};
        trial = {1'b0, sh} - {2'b0, i_d.den};
        n_d.num = {i_d.num[62:0], ~trial[33]};
        n_d.rem = trial[33] ? sh : trial[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= i_d.vld;
        end
        if (i_en) begin
            r_d.neg <= n_d.neg;
            r_d.num <= n_d.num;
            r_d.rem <= n_d.rem;
            r_d.den <= n_d.den;
            r_d.sum <= n_d.sum;
        end
    end

    assign o_d = r_d;
endmodule
